FILE: src/number_to_ascii_formatter_defines.svh
// assertion macros for the number to ascii formatter
`ifndef NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH
// checked outside reset
`define NTAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define NTAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/ntaf_pkg.sv
// types, constants and character helpers for the number to ascii formatter
package ntaf_pkg;

  localparam logic [1:0] MODE_SDEC  = 2'd0;
  localparam logic [1:0] MODE_HEX   = 2'd1;
  localparam logic [1:0] MODE_BDEC  = 2'd2;
  localparam logic [1:0] MODE_BHEX  = 2'd3;

  localparam int NUM_DIGITS  = 10;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int BIN_W       = 32;
  localparam int DD_STAGES   = 8;
  localparam int DD_STEPS    = BIN_W / DD_STAGES;

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_X     = 7'd120;
  localparam logic [6:0] CH_A     = 7'd65;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value_word;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_word_t;

  // word in flight through the double dabble stages
  typedef struct packed {
    logic [1:0]       mode;
    logic             neg;
    logic [31:0]      word;
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dd_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib > 4'd9) begin
      r = CH_A + {3'b000, nib - 4'd10};
    end else begin
      r = CH_ZERO + {3'b000, nib};
    end
    return r;
  endfunction

  function automatic logic [6:0] dec_char(input logic [3:0] dig);
    return CH_ZERO + {3'b000, dig};
  endfunction

endpackage

FILE: src/ntaf_dd_stage.sv
// one register stage of binary to bcd conversion, DD_STEPS (4) shift-add steps per stage
module ntaf_dd_stage import ntaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  dd_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output dd_t  dn_data
);

  dd_t data_next;

  always_comb begin
    dd_t t;
    t = up_data;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (t.bcd[4*k +: 4] > 4'd4) begin
          t.bcd[4*k +: 4] = t.bcd[4*k +: 4] + 4'd3;
        end
      end
      {t.bcd, t.bin} = {t.bcd[BCD_W-2:0], t.bin, 1'b0};
    end
    data_next = t;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

FILE: src/ntaf_serializer.sv
// turns converted digits into a stream of characters with an output register
module ntaf_serializer import ntaf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  dd_t       up_data,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word
);

  logic             busy;
  logic [1:0]       mode;
  logic             neg_pend;
  logic [BCD_W-1:0] bcd;
  logic [31:0]      word;
  logic [3:0]       pos;

  logic [3:0]  start_pos;
  logic [3:0]  dig;
  logic [3:0]  nib;
  out_word_t   cur;
  logic        out_adv;

  // start position: highest nonzero digit or nibble in modes 0 and 1, fixed for the byte modes
  always_comb begin
    start_pos = 4'd0;
    unique case (up_data.mode)
      MODE_SDEC: begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          if (up_data.bcd[4*k +: 4] != 4'd0) start_pos = 4'(k);
        end
      end
      MODE_HEX: begin
        for (int k = 0; k < 8; k++) begin
          if (up_data.word[4*k +: 4] != 4'd0) start_pos = 4'(k);
        end
      end
      MODE_BDEC: start_pos = 4'd2;
      MODE_BHEX: start_pos = 4'd4;
      default:   start_pos = 4'd0;
    endcase
  end

  assign dig = bcd[{pos, 2'b00} +: 4];
  assign nib = word[{pos[2:0], 2'b00} +: 4];

  always_comb begin
    cur.last_char = (pos == 4'd0) && !neg_pend;
    case (mode)
      MODE_SDEC: cur.char_code = neg_pend ? CH_MINUS : dec_char(dig);
      MODE_HEX:  cur.char_code = hex_char(nib);
      MODE_BDEC: cur.char_code = dec_char(dig);
      default: begin
        case (pos)
          4'd3:    cur.char_code = CH_X;
          4'd1:    cur.char_code = hex_char(word[7:4]);
          4'd0:    cur.char_code = hex_char(word[3:0]);
          default: cur.char_code = CH_ZERO;
        endcase
      end
    endcase
  end

  assign out_adv  = !dst_valid || !dst_stall;
  assign up_ready = !busy || (out_adv && cur.last_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (busy && out_adv) begin
        dst_valid <= 1'b1;
        dst_word  <= cur;
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else if (pos == 4'd0) begin
          // stays busy when the next word loads in the same cycle
          if (!up_valid) begin
            busy <= 1'b0;
          end
        end else begin
          pos <= pos - 4'd1;
        end
      end else if (out_adv) begin
        dst_valid <= 1'b0;
      end
      if (up_valid && up_ready) begin
        busy     <= 1'b1;
        mode     <= up_data.mode;
        neg_pend <= up_data.neg;
        bcd      <= up_data.bcd;
        word     <= up_data.word;
        pos      <= start_pos;
      end
    end
  end

endmodule

FILE: src/number_to_ascii_formatter.sv
// top level of the number to ascii formatter
// usage:
//   src channel takes one word per item: a 2-bit mode and a 32-bit value.
//   dst channel returns one ascii character per word, last_char marks the
//   final character of a value's text (1 to 11 characters per value).
//   mode 0 signed decimal, 1 hex without leading zeros, 2 low byte as three
//   decimal digits, 3 low byte as 0x0 plus two hex digits.
// path: a value passes the input register, 8 conversion stages of 4 shift-add
//   steps, the loader and the output register before its first character shows.
// throughput: the character emitter sends one character per cycle while dst is not
//   stalled, and it takes the next value while sending the last character of
//   the current one; the conversion stages keep feeding it back to back.
// reset clears all valid bits; no item is in flight afterwards.
// when dst is stalled the current character holds, the pipeline fills and
//   src_stall rises once every stage holds a word.
module number_to_ascii_formatter import ntaf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_word_t  src_word,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word
);

  logic       v [DD_STAGES+1];
  logic       r [DD_STAGES+2];
  dd_t        d [DD_STAGES+1];
  logic [31:0] mag;
  logic        neg;

  always_comb begin
    neg = (src_word.mode == MODE_SDEC) && src_word.value_word[31];
    if (neg) begin
      mag = 32'd0 - src_word.value_word;
    end else if (src_word.mode == MODE_SDEC) begin
      mag = src_word.value_word;
    end else begin
      mag = {24'd0, src_word.value_word[7:0]};
    end
  end

  assign r[0]      = !v[0] || r[1];
  assign src_stall = !r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (r[0]) begin
      v[0] <= src_valid;
    end
    if (r[0] && src_valid) begin
      d[0].mode <= src_word.mode;
      d[0].neg  <= neg;
      d[0].word <= src_word.value_word;
      d[0].bcd  <= '0;
      d[0].bin  <= mag;
    end
  end

  for (genvar i = 0; i < DD_STAGES; i++) begin : g_dd
    ntaf_dd_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (v[i]),
      .up_ready (r[i+1]),
      .up_data  (d[i]),
      .dn_valid (v[i+1]),
      .dn_ready (r[i+2]),
      .dn_data  (d[i+1])
    );
  end

  ntaf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (v[DD_STAGES]),
    .up_ready  (r[DD_STAGES+1]),
    .up_data   (d[DD_STAGES]),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

endmodule

FILE: src/ntaf_checker.sv
// port level checks for the number to ascii formatter
`include "number_to_ascii_formatter_defines.svh"
module ntaf_checker import ntaf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      src_valid,
  input logic      src_stall,
  input in_word_t  src_word,
  input logic      dst_valid,
  input logic      dst_stall,
  input out_word_t dst_word
);

  // a value's text goes out without gaps
  `NTAF_ASSERT(a_no_gap, dst_valid && !dst_stall && !dst_word.last_char |=> dst_valid, "gap inside text")
  // stalled character holds
  `NTAF_ASSERT(a_hold, dst_valid && dst_stall |=> dst_valid && $stable(dst_word), "stalled word changed")
  // nothing is shown right after reset
  `NTAF_ASSERT_ALWAYS(a_reset, rst |=> !dst_valid, "output valid after reset")
  // a minus sign is never the last character
  `NTAF_ASSERT(a_minus, dst_valid && dst_word.char_code == CH_MINUS |-> !dst_word.last_char, "text ends in minus")
  // a stalled input word holds
  `NTAF_ASSERT(a_src_hold, src_valid && src_stall |=> src_valid && $stable(src_word), "src moved")

endmodule

bind number_to_ascii_formatter ntaf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_word  (src_word),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_word  (dst_word)
);
